[hw/rtl/lsd_radix_string_sort_macros.svh]
// Assertion helpers for the radix sorter.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef LSD_RADIX_STRING_SORT_MACROS_SVH
`define LSD_RADIX_STRING_SORT_MACROS_SVH

// Same-cycle implication.
`define LSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lss: same-cycle check failed");

// Next-cycle implication.
`define LSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lss: next-cycle check failed");

`endif

[hw/rtl/lss_pkg.sv]
package lss_pkg;

    localparam int MAX_KEYS_DEF  = 64;
    localparam int KEY_CHARS_DEF = 8;
    localparam int ALPHABET_DEF  = 26;

    localparam int LETTER_W   = 5;
    localparam int LETTER_NUM = 8;
    localparam int KEY_PAD_W  = LETTER_W * LETTER_NUM;
    localparam int INDEX_W    = 6;
    localparam int KEY_LEN_W  = 4;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 4'd8;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_0;
        logic [LETTER_W-1:0] letter_1;
        logic [LETTER_W-1:0] letter_2;
        logic [LETTER_W-1:0] letter_3;
        logic [LETTER_W-1:0] letter_4;
        logic [LETTER_W-1:0] letter_5;
        logic [LETTER_W-1:0] letter_6;
        logic [LETTER_W-1:0] letter_7;
        logic                last_key;
    } key_t;

    typedef struct packed {
        logic [LETTER_W-1:0] out_letter_0;
        logic [LETTER_W-1:0] out_letter_1;
        logic [LETTER_W-1:0] out_letter_2;
        logic [LETTER_W-1:0] out_letter_3;
        logic [LETTER_W-1:0] out_letter_4;
        logic [LETTER_W-1:0] out_letter_5;
        logic [LETTER_W-1:0] out_letter_6;
        logic [LETTER_W-1:0] out_letter_7;
        logic [INDEX_W-1:0]  original_index;
        logic                last_result;
    } result_t;

endpackage

[hw/rtl/lss_ram.sv]
module lss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/lsd_radix_string_sort.sv]
// LSD radix sorter for short letter keys.
//
// Load: each word on key is taken at a clock edge with start high and busy
// low, one word a cycle. Letters above ALPHABET-1 are saturated; keys past
// MAX_KEYS are dropped. A word with last_key set (stored or dropped) starts
// the sort.
// Config: cfg_we/cfg_data write key_length (positions that take part in the
// order, position 0 most significant); write only while busy is low.
// Sort: one stable counting pass per position, last used position first.
// A pass streams the n held keys through the order RAM and key RAM (two
// registered reads) to count buckets, folds the ALPHABET counters with one
// adder, then streams the keys again to place them. After the last pass
// the keys stream through once more to the result port in sorted order.
// Results: one word per key, on result for one cycle with strobe high, in
// sorted order, last_result on the final one. The receiver cannot stall;
// results are never held back. busy drops as the final result appears.
// Reset: store empty, key_length back to 8, no results pending.
`include "lsd_radix_string_sort_macros.svh"

module lsd_radix_string_sort #(
    parameter int MAX_KEYS  = lss_pkg::MAX_KEYS_DEF,
    parameter int KEY_CHARS = lss_pkg::KEY_CHARS_DEF,
    parameter int ALPHABET  = lss_pkg::ALPHABET_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  lss_pkg::key_t                    key,
    input  logic                             cfg_we,
    input  logic [lss_pkg::KEY_LEN_W-1:0]    cfg_data,
    output logic                             strobe,
    output lss_pkg::result_t                 result
);

    localparam int LW    = lss_pkg::LETTER_W;
    localparam int AW    = $clog2(MAX_KEYS);
    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int BW    = $clog2(ALPHABET);
    localparam int PW    = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int KEY_W = KEY_CHARS * LW;
    localparam int PADW  = lss_pkg::KEY_PAD_W;
    localparam int KLW   = lss_pkg::KEY_LEN_W;

    // One-hot sequencer: load, then per pass count / fold / place, then emit.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_COUNT  = 5'b00010,
        ST_PREFIX = 5'b00100,
        ST_PLACE  = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t                 state_reg,    state_next;
    logic [KLW-1:0]         key_length_reg;
    logic [CW-1:0]          loaded_reg,   loaded_next;
    logic [CW-1:0]          n_reg,        n_next;
    logic [PW-1:0]          pos_reg,      pos_next;
    logic                   src_sel_reg,  src_sel_next;
    logic [CW-1:0]          idx_reg,      idx_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic [CW-1:0]          s1_idx_reg,   s1_idx_next;
    logic                   s2_valid_reg, s2_valid_next;
    logic [CW-1:0]          s2_idx_reg,   s2_idx_next;
    logic [AW-1:0]          s2_k_reg,     s2_k_next;
    logic [BW-1:0]          pidx_reg,     pidx_next;
    logic [CW-1:0]          acc_reg,      acc_next;
    logic [CW-1:0]          bucket_reg    [ALPHABET];
    logic [CW-1:0]          bucket_next   [ALPHABET];
    logic                   strobe_reg,   strobe_next;
    lss_pkg::result_t       result_reg,   result_next;

    logic                   accept;
    logic                   store_ok;
    logic                   issue;
    logic                   drained;
    logic [KLW-1:0]         kl_eff;
    logic [PW-1:0]          pos_start;
    logic [LW-1:0]          in_l        [lss_pkg::LETTER_NUM];
    logic [PADW-1:0]        key_all;
    logic [KEY_W-1:0]       key_wdata;
    logic [KEY_W-1:0]       key_rd;
    logic [PADW-1:0]        key_pad;
    logic [LW-1:0]          out_l       [lss_pkg::LETTER_NUM];
    logic [LW-1:0]          s2_letter;
    logic [BW-1:0]          s2_bucket;
    logic [BW-1:0]          bucket_addr;
    logic [CW-1:0]          bucket_rd;
    logic [CW-1:0]          bucket_dec;
    logic [CW-1:0]          fold_sum;
    logic [AW-1:0]          order_raddr;
    logic [AW-1:0]          order_rd_a;
    logic [AW-1:0]          order_rd_b;
    logic [AW-1:0]          k_s1;
    logic                   place_wr;
    logic                   we_a;
    logic [AW-1:0]          waddr_a;
    logic [AW-1:0]          wdata_a;
    logic                   we_b;
    logic                   key_we;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign store_ok = (loaded_reg < CW'(MAX_KEYS));
    assign strobe   = strobe_reg;
    assign result   = result_reg;

    // Out-of-range lengths clamp to 1..KEY_CHARS.
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            kl_eff = KLW'(1);
        end
        else if (key_length_reg > KLW'(KEY_CHARS))
        begin
            kl_eff = KLW'(KEY_CHARS);
        end
        else
        begin
            kl_eff = key_length_reg;
        end
    end
    assign pos_start = PW'(kl_eff - KLW'(1));

    // Load path: saturate letters, keep only the stored positions.
    always_comb
    begin
        in_l[0] = key.letter_0;
        in_l[1] = key.letter_1;
        in_l[2] = key.letter_2;
        in_l[3] = key.letter_3;
        in_l[4] = key.letter_4;
        in_l[5] = key.letter_5;
        in_l[6] = key.letter_6;
        in_l[7] = key.letter_7;
        for (int p = 0; p < lss_pkg::LETTER_NUM; p++)
        begin
            if ({1'b0, in_l[p]} >= (LW + 1)'(ALPHABET))
            begin
                key_all[p*LW +: LW] = LW'(ALPHABET - 1);
            end
            else
            begin
                key_all[p*LW +: LW] = in_l[p];
            end
        end
    end
    assign key_wdata = KEY_W'(key_all);
    assign key_we    = accept && store_ok;

    // Stream control shared by count, place and emit.
    assign issue    = (state_reg == ST_COUNT || state_reg == ST_PLACE || state_reg == ST_EMIT)
                      && (idx_reg < n_reg);
    assign drained  = !issue && !s1_valid_reg && !s2_valid_reg;

    // Placing walks the source order backwards to keep the sort stable.
    assign order_raddr = (state_reg == ST_PLACE) ? AW'(n_reg - CW'(1) - idx_reg)
                                                 : AW'(idx_reg);
    assign k_s1        = src_sel_reg ? order_rd_b : order_rd_a;

    // Stage two: letter at the current position picks the bucket.
    assign key_pad     = PADW'(key_rd);
    assign s2_letter   = key_pad[int'(pos_reg)*LW +: LW];
    assign s2_bucket   = s2_letter[BW-1:0];
    assign bucket_addr = (state_reg == ST_PREFIX) ? pidx_reg : s2_bucket;
    assign bucket_rd   = bucket_reg[bucket_addr];
    assign bucket_dec  = bucket_rd - CW'(1);
    assign fold_sum    = bucket_rd + acc_reg;

    always_comb
    begin
        for (int p = 0; p < lss_pkg::LETTER_NUM; p++)
        begin
            out_l[p] = (p < KEY_CHARS) ? key_pad[p*LW +: LW] : '0;
        end
    end

    // Order buffers: A takes the identity order at load; the destination of
    // each pass is whichever buffer is not the source.
    assign place_wr = (state_reg == ST_PLACE) && s2_valid_reg;
    assign we_a     = key_we || (place_wr && src_sel_reg);
    assign waddr_a  = key_we ? loaded_reg[AW-1:0] : bucket_dec[AW-1:0];
    assign wdata_a  = key_we ? loaded_reg[AW-1:0] : s2_k_reg;
    assign we_b     = place_wr && !src_sel_reg;

    lss_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_store (
        .clk   (clk),
        .we    (key_we),
        .waddr (loaded_reg[AW-1:0]),
        .wdata (key_wdata),
        .raddr (k_s1),
        .rdata (key_rd)
    );

    lss_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_KEYS)
    ) u_order_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (wdata_a),
        .raddr (order_raddr),
        .rdata (order_rd_a)
    );

    lss_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_KEYS)
    ) u_order_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (bucket_dec[AW-1:0]),
        .wdata (s2_k_reg),
        .raddr (order_raddr),
        .rdata (order_rd_b)
    );

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        n_next        = n_reg;
        pos_next      = pos_reg;
        src_sel_next  = src_sel_reg;
        idx_next      = idx_reg;
        pidx_next     = pidx_reg;
        acc_next      = acc_reg;
        bucket_next   = bucket_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        s1_valid_next = issue;
        s1_idx_next   = idx_reg;
        s2_valid_next = s1_valid_reg;
        s2_idx_next   = s1_idx_reg;
        s2_k_next     = k_s1;

        if (issue)
        begin
            idx_next = idx_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (store_ok)
                    begin
                        loaded_next = loaded_reg + CW'(1);
                    end
                    if (key.last_key)
                    begin
                        n_next       = store_ok ? loaded_reg + CW'(1) : loaded_reg;
                        loaded_next  = '0;
                        pos_next     = pos_start;
                        src_sel_next = 1'b0;
                        idx_next     = '0;
                        for (int b = 0; b < ALPHABET; b++)
                        begin
                            bucket_next[b] = '0;
                        end
                        state_next   = ST_COUNT;
                    end
                end
            end
            ST_COUNT:
            begin
                if (s2_valid_reg)
                begin
                    bucket_next[s2_bucket] = bucket_rd + CW'(1);
                end
                if (drained)
                begin
                    pidx_next  = '0;
                    acc_next   = '0;
                    state_next = ST_PREFIX;
                end
            end
            ST_PREFIX:
            begin
                // Running sum turns counts into bucket end positions.
                bucket_next[pidx_reg] = fold_sum;
                acc_next              = fold_sum;
                if (pidx_reg == BW'(ALPHABET - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_PLACE;
                end
                else
                begin
                    pidx_next = pidx_reg + BW'(1);
                end
            end
            ST_PLACE:
            begin
                if (s2_valid_reg)
                begin
                    bucket_next[s2_bucket] = bucket_dec;
                end
                if (drained)
                begin
                    src_sel_next = !src_sel_reg;
                    idx_next     = '0;
                    if (pos_reg == '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        pos_next = pos_reg - PW'(1);
                        for (int b = 0; b < ALPHABET; b++)
                        begin
                            bucket_next[b] = '0;
                        end
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_EMIT:
            begin
                strobe_next = s2_valid_reg;
                result_next.out_letter_0   = out_l[0];
                result_next.out_letter_1   = out_l[1];
                result_next.out_letter_2   = out_l[2];
                result_next.out_letter_3   = out_l[3];
                result_next.out_letter_4   = out_l[4];
                result_next.out_letter_5   = out_l[5];
                result_next.out_letter_6   = out_l[6];
                result_next.out_letter_7   = out_l[7];
                result_next.original_index = lss_pkg::INDEX_W'(s2_k_reg);
                result_next.last_result    = (s2_idx_reg == n_reg - CW'(1));
                // Leave as the final word goes out, so busy drops with it.
                if (!issue && !s1_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_length_reg <= lss_pkg::KEY_LEN_RESET;
            loaded_reg     <= '0;
            n_reg          <= '0;
            pos_reg        <= '0;
            src_sel_reg    <= 1'b0;
            idx_reg        <= '0;
            pidx_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                key_length_reg <= cfg_data;
            end
            loaded_reg   <= loaded_next;
            n_reg        <= n_next;
            pos_reg      <= pos_next;
            src_sel_reg  <= src_sel_next;
            idx_reg      <= idx_next;
            pidx_reg     <= pidx_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            strobe_reg   <= strobe_next;
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= s1_idx_next;
        s2_idx_reg <= s2_idx_next;
        s2_k_reg   <= s2_k_next;
        acc_reg    <= acc_next;
        bucket_reg <= bucket_next;
        result_reg <= result_next;
    end

    // Checks.
    `LSS_ASSERT_NOW(a_idle_empty, !busy, !s1_valid_reg && !s2_valid_reg)
    `LSS_ASSERT_NEXT(a_emit_strobe, (state_reg == ST_EMIT) && s2_valid_reg, strobe)
    `LSS_ASSERT_NOW(a_last_frees, strobe && result.last_result, !busy)
    `LSS_ASSERT_NOW(a_store_bound, 1'b1, loaded_reg <= CW'(MAX_KEYS))

endmodule

[tb/sv/lsd_radix_string_sort_tb.sv]
module lsd_radix_string_sort_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lss_pkg::*;

    // Cycles with no word moving on either side before the run is abandoned.
    // Worst legitimate gap: a full 64-key set sorted over 8 positions.
    localparam int WATCHDOG_LIMIT = 20000;
    // Quiet cycles before a key_length write, so a trailing load has settled.
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_WORDS   = 280;
    localparam int KEY_W          = $bits(key_t);
    localparam int MAX_REPORTS    = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    key_t                 key;
    logic                 cfg_we;
    logic [KEY_LEN_W-1:0] cfg_data;
    logic                 strobe;
    result_t              result;

    lsd_radix_string_sort DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .key      (key),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .strobe   (strobe),
        .result   (result)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the key store and of key_length.
    // ------------------------------------------------------------------
    logic [LETTER_W-1:0]  held_letters [MAX_KEYS_DEF][LETTER_NUM];
    int                   held_count;
    logic [KEY_LEN_W-1:0] sort_len;

    // Sorted words still owed by the block, oldest first.
    result_t sorted_due [$];

    int fails;
    int quiet_cycles;

    // One row of the directed plan. new_len < 0 leaves key_length alone;
    // typed rows carry the single result written out by hand.
    typedef struct {
        int      new_len;
        key_t    word;
        bit      typed;
        result_t want;
    } step_row_t;

    step_row_t plan [$];

    function automatic step_row_t row(input int new_len,
                                      input logic [KEY_PAD_W-1:0] letters,
                                      input bit last,
                                      input bit typed = 1'b0,
                                      input logic [KEY_PAD_W-1:0] want_letters = '0);
        step_row_t r;
        r.new_len = new_len;
        r.word    = key_t'({letters, last});
        r.typed   = typed;
        // hand-typed rows are always one-key sets: index 0, flagged final
        r.want    = result_t'({want_letters, INDEX_W'(0), 1'b1});
        return r;
    endfunction

    // Loads one word into the predictor's store and, on last_key, returns
    // the whole set in sorted order (stable, first sort_len positions).
    function automatic void sort_word(input key_t w, ref result_t emitted [$]);
        logic [KEY_PAD_W-1:0] flat;
        logic [LETTER_W-1:0]  ltr;
        int                   order [MAX_KEYS_DEF];
        int                   used, i, j, p, cmp, t;
        flat = w[KEY_W-1:1];
        emitted.delete();
        // a full store silently drops the word, last_key still counts
        if (held_count < MAX_KEYS_DEF)
        begin
            for (p = 0; p < LETTER_NUM; p++)
            begin
                ltr = flat[KEY_PAD_W-1-LETTER_W*p -: LETTER_W];
                if (ltr >= ALPHABET_DEF)
                    ltr = LETTER_W'(ALPHABET_DEF - 1);
                held_letters[held_count][p] = (p < KEY_CHARS_DEF) ? ltr : '0;
            end
            held_count++;
        end
        if (!w.last_key)
            return;

        // 0 behaves as 1, anything past KEY_CHARS as KEY_CHARS
        used = int'(sort_len);
        if (used == 0)
            used = 1;
        if (used > KEY_CHARS_DEF)
            used = KEY_CHARS_DEF;

        for (i = 0; i < held_count; i++)
            order[i] = i;

        // insertion sort; only a strictly greater key moves down, so ties
        // keep load order
        for (i = 1; i < held_count; i++)
        begin
            for (j = i; j > 0; j--)
            begin
                cmp = 0;
                // least significant first: the last difference seen wins
                for (p = used - 1; p >= 0; p--)
                begin
                    if (held_letters[order[j-1]][p] != held_letters[order[j]][p])
                        cmp = (held_letters[order[j-1]][p] > held_letters[order[j]][p])
                              ? 1 : -1;
                end
                if (cmp <= 0)
                    break;
                t          = order[j];
                order[j]   = order[j-1];
                order[j-1] = t;
            end
        end

        for (i = 0; i < held_count; i++)
        begin
            t = order[i];
            emitted.push_back(result_t'({held_letters[t][0], held_letters[t][1],
                                         held_letters[t][2], held_letters[t][3],
                                         held_letters[t][4], held_letters[t][5],
                                         held_letters[t][6], held_letters[t][7],
                                         INDEX_W'(t), (i == held_count - 1)}));
        end
        held_count = 0;
    endfunction

    // Offers one word, with random idle cycles in front at idle_pct percent.
    // Returns at the edge that accepted it, start still high.
    task automatic push_word(input key_t w, input int idle_pct, ref result_t emitted [$]);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            key   <= key_t'(KEY_W'({$urandom(), $urandom()}));
            @(posedge clk);
        end
        start <= 1'b1;
        key   <= w;
        // busy read here is the value before the edge
        do
            @(posedge clk);
        while (busy);
        sort_word(w, emitted);
    endtask

    // key_length may only change with the block idle and the store empty.
    task automatic write_len(input int v);
        start <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= KEY_LEN_W'(v);
        @(posedge clk);
        cfg_we   <= 1'b0;
        sort_len = KEY_LEN_W'(v);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog. Outputs are read straight after the
    // edge, before the block's own updates land, so each word seen is the
    // one accepted at that edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t exp_word;
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else if (strobe)
            begin
                if (sorted_due.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("unexpected sorted word %h at %0t", result, $realtime);
                end
                else
                begin
                    exp_word = sorted_due.pop_front();
                    if ({result.out_letter_0, result.out_letter_1, result.out_letter_2,
                         result.out_letter_3, result.out_letter_4, result.out_letter_5,
                         result.out_letter_6, result.out_letter_7}
                        !== {exp_word.out_letter_0, exp_word.out_letter_1,
                             exp_word.out_letter_2, exp_word.out_letter_3,
                             exp_word.out_letter_4, exp_word.out_letter_5,
                             exp_word.out_letter_6, exp_word.out_letter_7}
                        || result.original_index !== exp_word.original_index
                        || result.last_result !== exp_word.last_result)
                    begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("sorted word mismatch at %0t: letters exp %h got %h, ",
                                     $realtime, exp_word[KEY_PAD_W+INDEX_W:INDEX_W+1],
                                     result[KEY_PAD_W+INDEX_W:INDEX_W+1],
                                     "index exp %0d got %0d, last exp %b got %b",
                                     exp_word.original_index, result.original_index,
                                     exp_word.last_result, result.last_result);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        result_t              got [$];
        key_t                 w;
        key_t                 prev;
        logic [KEY_PAD_W-1:0] flat;
        int                   r, k, p, n, idle_pct, sent, phase, set_no, len;
        bit                   narrow;

        rst_n        = 1'b0;
        start        = 1'b0;
        key          = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        held_count   = 0;
        sort_len     = KEY_LEN_RESET;
        fails        = 0;
        quiet_cycles = 0;
        prev         = '0;

        // Directed plan. Single-key sets are typed in; the rest go through
        // the predictor.
        // reset key_length (8): extremes and saturation of letters
        plan.push_back(row(-1, {8{5'd0}},  1'b1, 1'b1, {8{5'd0}}));
        plan.push_back(row(-1, {8{5'd25}}, 1'b1, 1'b1, {8{5'd25}}));
        plan.push_back(row(-1, {8{5'd31}}, 1'b1, 1'b1, {8{5'd25}}));
        plan.push_back(row(-1, {8{5'd26}}, 1'b1, 1'b1, {8{5'd25}}));
        // order decided at the last position, plus a duplicate for stability
        plan.push_back(row(-1, {5'd1, {6{5'd0}}, 5'd3}, 1'b0));
        plan.push_back(row(-1, {5'd1, {6{5'd0}}, 5'd2}, 1'b0));
        plan.push_back(row(-1, {5'd0, {7{5'd9}}},       1'b0));
        plan.push_back(row(-1, {5'd1, {6{5'd0}}, 5'd2}, 1'b1));
        // key_length 0 acts as 1: position 1 must not reorder
        plan.push_back(row(0,  {5'd4, 5'd1, {6{5'd0}}}, 1'b0));
        plan.push_back(row(-1, {5'd3, 5'd9, {6{5'd0}}}, 1'b0));
        plan.push_back(row(-1, {5'd4, 5'd0, {6{5'd0}}}, 1'b1));
        // key_length 15 clamps to 8
        plan.push_back(row(15, {{7{5'd5}}, 5'd7}, 1'b0));
        plan.push_back(row(-1, {{7{5'd5}}, 5'd6}, 1'b1));
        // key_length 3: tail letters ride along, unsorted
        plan.push_back(row(3,  {5'd2, 5'd2, 5'd2, {5{5'd31}}}, 1'b0));
        plan.push_back(row(-1, {5'd2, 5'd2, 5'd2, {5{5'd0}}},  1'b0));
        plan.push_back(row(-1, {5'd2, 5'd2, 5'd1, {5{5'd21}}}, 1'b1));
        // alternating bit patterns on every letter
        plan.push_back(row(1,  {4{5'd21, 5'd10}}, 1'b1, 1'b1, {4{5'd21, 5'd10}}));
        plan.push_back(row(8,  {4{5'd10, 5'd21}}, 1'b1, 1'b1, {4{5'd10, 5'd21}}));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < plan.size(); r++)
        begin
            if (plan[r].new_len >= 0)
                write_len(plan[r].new_len);
            push_word(plan[r].word, 0, got);
            if (plan[r].typed)
                sorted_due.push_back(plan[r].want);
            else
                foreach (got[q])
                    sorted_due.push_back(got[q]);
        end

        // Random phases: each picks a key_length and an idling rate, then
        // loads a few sets. Phase 1 opens with an overflowing set so the
        // final, dropped word has to trigger the sort.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            case (phase % 5)
                0:       len = 8;
                1:       len = 0;
                2:       len = 15;
                3:       len = 1;
                default: len = $urandom_range(0, 15);
            endcase
            write_len(len);
            idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 71 : 29;

            for (set_no = 0; set_no < 3; set_no++)
            begin
                if (phase == 1 && set_no == 0)
                    n = MAX_KEYS_DEF + 2;
                else if ($urandom_range(0, 24) == 0)
                    n = MAX_KEYS_DEF;
                else
                    n = $urandom_range(1, 10);
                // a narrow alphabet forces ties deep into the key
                narrow = $urandom_range(0, 1);

                for (k = 0; k < n; k++)
                begin
                    if (k > 0 && $urandom_range(0, 5) == 0)
                        w = prev;
                    else
                    begin
                        for (p = 0; p < LETTER_NUM; p++)
                        begin
                            if (narrow)
                                flat[KEY_PAD_W-1-LETTER_W*p -: LETTER_W] =
                                    LETTER_W'($urandom_range(0, 2));
                            else if ($urandom_range(0, 7) == 0)
                                flat[KEY_PAD_W-1-LETTER_W*p -: LETTER_W] =
                                    LETTER_W'($urandom_range(ALPHABET_DEF, 31));
                            else
                                flat[KEY_PAD_W-1-LETTER_W*p -: LETTER_W] =
                                    LETTER_W'($urandom_range(0, ALPHABET_DEF - 1));
                        end
                        w = key_t'({flat, 1'b0});
                    end
                    w.last_key = (k == n - 1);
                    push_word(w, idle_pct, got);
                    foreach (got[q])
                        sorted_due.push_back(got[q]);
                    prev = w;
                    sent++;
                end
            end
            phase++;
        end

        start <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0 && sorted_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
